>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define BMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define BMT_NEVER(lbl, expr, msg) \
  `BMT_ASSERT(lbl, !(expr), msg)

`endif

>>> rtl/core/bmt_pkg.sv
// ---------------------------------------------------------------------------
// Breakpoint match table package
// Operation codes, the token that walks the cell chain and default sizes.
// ---------------------------------------------------------------------------
package bmt_pkg;

  localparam int DEFAULT_DEPTH = 128;
  localparam int FILE_W        = 16;
  localparam int LINE_W        = 16;
  localparam int COUNT_OUT_W   = 8;

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_SET      = 2'd1,
    OP_CLR_FILE = 2'd2,
    OP_CLR_ALL  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic              act;
    opcode_t           op;
    logic [FILE_W-1:0] file_id;
    logic [LINE_W-1:0] line_no;
    logic              hit;
    logic              acc;
    logic              pend;
  } tok_t;

endpackage

>>> rtl/core/bmt_cell.sv
// ---------------------------------------------------------------------------
// Breakpoint match table cell
// Holds one table entry and applies the passing operation token to it.
// ---------------------------------------------------------------------------
module bmt_cell #(
  parameter int CNT_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  bmt_pkg::tok_t    tok_in,
  input  logic [CNT_W-1:0] rm_in,
  output bmt_pkg::tok_t    tok_out,
  output logic [CNT_W-1:0] rm_out
);

  logic                       valid;
  logic                       valid_next;
  logic [bmt_pkg::FILE_W-1:0] file_id;
  logic [bmt_pkg::LINE_W-1:0] line_no;
  logic                       store;
  logic                       file_eq;
  bmt_pkg::tok_t              tok_next;
  logic [CNT_W-1:0]           rm_next;

  assign file_eq = valid && (file_id == tok_in.file_id);

  always_comb begin
    tok_next   = tok_in;
    rm_next    = rm_in;
    valid_next = valid;
    store      = 1'b0;
    if (tok_in.act) begin
      case (tok_in.op)
        bmt_pkg::OP_LOOKUP: begin
          if (file_eq && (line_no == tok_in.line_no)) begin
            tok_next.hit = 1'b1;
          end
        end
        bmt_pkg::OP_SET: begin
          if (tok_in.pend && !valid) begin
            store         = 1'b1;
            valid_next    = 1'b1;
            tok_next.pend = 1'b0;
          end
        end
        bmt_pkg::OP_CLR_FILE: begin
          if (file_eq) begin
            valid_next = 1'b0;
            rm_next    = rm_in + CNT_W'(1);
          end
        end
        default: begin
          valid_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      tok_out.act <= 1'b0;
    end else begin
      valid       <= valid_next;
      tok_out.act <= tok_next.act;
    end
    tok_out.op      <= tok_next.op;
    tok_out.file_id <= tok_next.file_id;
    tok_out.line_no <= tok_next.line_no;
    tok_out.hit     <= tok_next.hit;
    tok_out.acc     <= tok_next.acc;
    tok_out.pend    <= tok_next.pend;
    rm_out          <= rm_next;
    if (store) begin
      file_id <= tok_in.file_id;
      line_no <= tok_in.line_no;
    end
  end

endmodule

>>> rtl/core/breakpoint_match_table.sv
// ---------------------------------------------------------------------------
// Breakpoint match table
// Stores (file id, line) breakpoints and answers lookup, set and clear
// operations, one transaction at a time, through a chain of entry cells.
// ---------------------------------------------------------------------------
// Each slave transaction carries an opcode in s_tuser and the file id and
// line number in s_tdata. Each one produces exactly one master transaction
// with the hit flag, the accepted flag and the entry count after the
// operation.
// The operation enters a head register and then walks the chain of
// DEPTH cells, one cell per cycle, and the result is then loaded into the
// output register. Only one operation is in the chain at a time; the next
// operation may enter in the cycle after the result is loaded.
// A new operation is only taken when the output register is free or is
// being emptied in the same cycle; while the receiver stalls, the result
// holds and s_tready stays low.
// Reset empties every cell and clears the entry count.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module breakpoint_match_table #(
  parameter int DEPTH = bmt_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  input  logic [31:0] s_tdata,   // file_id[15:0], line_no[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // hit[0], accepted[1], entry_count[9:2], zero[15:10]
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  bmt_pkg::tok_t    chain_tok [DEPTH+1];
  logic [CNT_W-1:0] chain_rm  [DEPTH+1];
  logic [DEPTH:0]   chain_act;

  logic                            busy;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_next;
  logic                            in_acc;
  logic                            done;
  bmt_pkg::tok_t                   tail;
  bmt_pkg::opcode_t                in_op;
  logic                            can_set;
  logic                            res_hit;
  logic                            res_acc;
  logic [bmt_pkg::COUNT_OUT_W-1:0] res_count;

  assign in_op    = bmt_pkg::opcode_t'(s_tuser);
  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign in_acc   = s_tvalid && s_tready;
  assign tail     = chain_tok[DEPTH];
  assign done     = tail.act;
  assign can_set  = (in_op == bmt_pkg::OP_SET) && (count < CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_tok[0].act <= 1'b0;
    end else begin
      chain_tok[0].act <= in_acc;
    end
    if (in_acc) begin
      chain_tok[0].op      <= in_op;
      chain_tok[0].file_id <= s_tdata[15:0];
      chain_tok[0].line_no <= s_tdata[31:16];
      chain_tok[0].hit     <= 1'b0;
      chain_tok[0].acc     <= can_set;
      chain_tok[0].pend    <= can_set && (s_tdata[15:0] != '0);
      chain_rm[0]          <= '0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bmt_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain_tok[i]),
      .rm_in   (chain_rm[i]),
      .tok_out (chain_tok[i+1]),
      .rm_out  (chain_rm[i+1])
    );
  end

  for (genvar i = 0; i <= DEPTH; i++) begin : g_act
    assign chain_act[i] = chain_tok[i].act;
  end

  always_comb begin
    case (tail.op)
      bmt_pkg::OP_SET: begin
        count_next = (tail.acc && (tail.file_id != '0)) ? count + CNT_W'(1) : count;
      end
      bmt_pkg::OP_CLR_FILE: begin
        count_next = count - chain_rm[DEPTH];
      end
      bmt_pkg::OP_CLR_ALL: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (done) begin
      res_hit   <= (tail.op == bmt_pkg::OP_LOOKUP) && tail.hit;
      res_acc   <= tail.acc;
      res_count <= bmt_pkg::COUNT_OUT_W'(count_next);
    end
  end

  assign m_tdata = {6'b0, res_count, res_acc, res_hit};

  `BMT_ASSERT(a_count_range, count <= CNT_W'(DEPTH), "entry count exceeds table depth")
  `BMT_ASSERT(a_one_token, $countones(chain_act) <= 1, "more than one operation in the chain")
  `BMT_NEVER(a_out_overrun, done && m_tvalid && !m_tready, "result overwrites an untaken result")
  `BMT_NEVER(a_set_lost, done && tail.pend, "accepted set found no free cell")

endmodule

>>> bench/breakpoint_match_table_checker.sv
// ---------------------------------------------------------------------------
// Breakpoint match table checker
// Watches both stream channels of the table. It keeps its own copy of the
// stored breakpoints, works out the result of every accepted input
// transaction, and compares each output transaction field by field with the
// oldest result still due.
// ---------------------------------------------------------------------------
module breakpoint_match_table_checker #(
  parameter int DEPTH = bmt_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [1:0]  s_tuser,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          failures,
  output int          outstanding
);

  typedef struct packed {
    logic       hit;
    logic       accepted;
    logic [7:0] count;
  } bp_result_t;

  logic [bmt_pkg::FILE_W-1:0] bp_file [DEPTH];
  logic [bmt_pkg::LINE_W-1:0] bp_line [DEPTH];
  int unsigned                bp_valid;
  int                         fail_count;
  bp_result_t                 due_q [$];

  // Valid entries are kept packed at the low slots.
  function automatic bp_result_t apply_operation(input bmt_pkg::opcode_t op,
                                                 input logic [bmt_pkg::FILE_W-1:0] f,
                                                 input logic [bmt_pkg::LINE_W-1:0] l);
    bp_result_t  r;
    int unsigned wr;
    r  = '0;
    wr = 0;
    case (op)
      bmt_pkg::OP_LOOKUP: begin
        if (f != '0) begin
          for (int unsigned i = 0; i < bp_valid; i++) begin
            if (bp_file[i] == f && bp_line[i] == l) begin
              r.hit = 1'b1;
            end
          end
        end
      end
      bmt_pkg::OP_SET: begin
        if (bp_valid < DEPTH) begin
          r.accepted = 1'b1;
          if (f != '0) begin
            bp_file[bp_valid] = f;
            bp_line[bp_valid] = l;
            bp_valid++;
          end
        end
      end
      bmt_pkg::OP_CLR_FILE: begin
        if (f != '0) begin
          for (int unsigned i = 0; i < bp_valid; i++) begin
            if (bp_file[i] != f) begin
              bp_file[wr] = bp_file[i];
              bp_line[wr] = bp_line[i];
              wr++;
            end
          end
          bp_valid = wr;
        end
      end
      default: begin
        bp_valid = 0;
      end
    endcase
    r.count = 8'(bp_valid);
    return r;
  endfunction

  always @(posedge clk) begin
    bp_result_t got;
    bp_result_t want;
    if (rst) begin
      due_q.delete();
      bp_valid   = 0;
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.hit      = m_tdata[0];
        got.accepted = m_tdata[1];
        got.count    = m_tdata[9:2];
        if (due_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing due: expected none, actual %h", $time, m_tdata);
        end else begin
          want = due_q.pop_front();
          if (got.hit !== want.hit) begin
            fail_count++;
            $display("%0t: hit mismatch: expected %0d, actual %0d",
                     $time, want.hit, got.hit);
          end
          if (got.accepted !== want.accepted) begin
            fail_count++;
            $display("%0t: accepted mismatch: expected %0d, actual %0d",
                     $time, want.accepted, got.accepted);
          end
          if (got.count !== want.count) begin
            fail_count++;
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, want.count, got.count);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        due_q.push_back(apply_operation(bmt_pkg::opcode_t'(s_tuser),
                                        s_tdata[15:0], s_tdata[31:16]));
      end
    end
    failures    <= fail_count;
    outstanding <= due_q.size();
  end

endmodule

>>> bench/breakpoint_match_table_tb.sv
// ---------------------------------------------------------------------------
// Breakpoint match table testbench
// Drives lookup, set and clear transactions into the table with random gaps
// and random output stalls, including a long output stall and a full drain.
// A directed opening covers the edge cases; random phases then fill the
// table to capacity and drain it again. The checker decides the verdict.
// ---------------------------------------------------------------------------
module breakpoint_match_table_tb;

  localparam int DEPTH        = bmt_pkg::DEFAULT_DEPTH;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int LONG_HOLD    = 600;
  localparam int MODE_FILL    = 0;
  localparam int MODE_MIXED   = 1;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser  = bmt_pkg::OP_LOOKUP;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int failures;
  int outstanding;
  bit tx_burst      = 1'b0;
  bit rx_burst      = 1'b0;
  bit long_hold_req = 1'b0;

  always #2 clk = ~clk;

  breakpoint_match_table #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  breakpoint_match_table_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .failures(failures),
    .outstanding(outstanding)
  );

  task automatic send_item(input bmt_pkg::opcode_t op, input logic [15:0] f,
                           input logic [15:0] l);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {l, f};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_item(input int mode);
    int               pick;
    bmt_pkg::opcode_t op;
    logic [15:0]      f;
    logic [15:0]      l;
    pick = $urandom_range(0, 99);
    if (mode == MODE_FILL) begin
      if (pick < 75) op = bmt_pkg::OP_SET;
      else if (pick < 99) op = bmt_pkg::OP_LOOKUP;
      else op = bmt_pkg::OP_CLR_FILE;
    end else begin
      if (pick < 50) op = bmt_pkg::OP_LOOKUP;
      else if (pick < 85) op = bmt_pkg::OP_SET;
      else if (pick < 97) op = bmt_pkg::OP_CLR_FILE;
      else op = bmt_pkg::OP_CLR_ALL;
    end
    f = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
    l = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    send_item(op, f, l);
  endtask

  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    int mode;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(bmt_pkg::OP_LOOKUP,   16'hFFFF, 16'hFFFF);
    send_item(bmt_pkg::OP_CLR_FILE, 16'hFFFF, 16'h0000);
    send_item(bmt_pkg::OP_SET,      16'hFFFF, 16'hFFFF);
    send_item(bmt_pkg::OP_SET,      16'h0001, 16'h0000);
    send_item(bmt_pkg::OP_SET,      16'h0000, 16'h1234);
    send_item(bmt_pkg::OP_SET,      16'hFFFF, 16'hFFFF);
    send_item(bmt_pkg::OP_LOOKUP,   16'hFFFF, 16'hFFFF);
    send_item(bmt_pkg::OP_LOOKUP,   16'h0001, 16'h0000);
    send_item(bmt_pkg::OP_LOOKUP,   16'h0000, 16'h0000);
    send_item(bmt_pkg::OP_LOOKUP,   16'h0001, 16'h0001);
    send_item(bmt_pkg::OP_CLR_FILE, 16'h0000, 16'hFFFF);
    send_item(bmt_pkg::OP_CLR_FILE, 16'hFFFF, 16'h0000);
    send_item(bmt_pkg::OP_LOOKUP,   16'hFFFF, 16'hFFFF);
    send_item(bmt_pkg::OP_SET,      16'h8000, 16'h5555);
    send_item(bmt_pkg::OP_SET,      16'h7FFF, 16'hAAAA);
    send_item(bmt_pkg::OP_LOOKUP,   16'h8000, 16'h5555);
    send_item(bmt_pkg::OP_LOOKUP,   16'h7FFF, 16'h5555);
    send_item(bmt_pkg::OP_CLR_ALL,  16'hA5A5, 16'h5A5A);
    send_item(bmt_pkg::OP_LOOKUP,   16'h0001, 16'h0000);
    send_item(bmt_pkg::OP_SET,      16'h0001, 16'hFFFF);
    send_item(bmt_pkg::OP_CLR_ALL,  16'h0000, 16'h0000);

    // Two filling phases out of three take the table to capacity, so that
    // sets on a full table are rejected; the mixed phase drains it again.
    for (int ph = 0; ph < PHASES; ph++) begin
      mode     = (ph % 3 == 2) ? MODE_MIXED : MODE_FILL;
      tx_burst = (ph % 4 == 1);
      rx_burst = (ph % 4 == 3);
      if (ph == 3) long_hold_req = 1'b1;
      if (ph == 6) wait_for_drain();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item(mode);
      end
    end

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
    if (failures == 0) begin
      $display("** breakpoint_match_table: PASSED **");
    end else begin
      $display("** breakpoint_match_table: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("** breakpoint_match_table: FAILED **");
    $finish;
  end

endmodule
